/* src/sha256_pkg.sv */
// sha256_pkg: shared types, constants and round functions for the sha-256 stream hasher
// depends on nothing
package sha256_pkg;

  localparam int QueueDepth = 4;

  // front-end operation codes
  typedef enum logic [0:0] {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // word moved from front to back through the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  localparam logic [255:0] InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

/* src/sha256_queue.sv */
// sha256_queue: small fifo of command words between the front and back parts
// depends on sha256_pkg
module sha256_queue #(
  parameter int Depth = sha256_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  sha256_pkg::cmd_t  wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sha256_pkg::cmd_t  rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha256_pkg::cmd_t mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

/* src/sha256_front.sv */
// sha256_front: input stage that accepts words and classifies them into commands
// depends on sha256_pkg
module sha256_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [7:0]       in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output sha256_pkg::cmd_t cmd
);

  logic             held;
  sha256_pkg::cmd_t held_cmd;

  assign in_ready  = !held || cmd_ready;
  assign cmd_valid = held;
  assign cmd       = held_cmd;

  // register stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_cmd.op   <= sha256_pkg::op_t'(in_op);
      held_cmd.data <= in_data;
    end
  end

endmodule

/* src/sha256_back.sv */
// sha256_back: block buffer, message schedule, round engine and digest output
// depends on sha256_pkg
module sha256_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  sha256_pkg::cmd_t cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_word,
  output logic [2:0]       out_index,
  output logic             out_last
);

  sha256_pkg::state_t state, state_next;

  logic [31:0]  buf_mem [16];
  logic [5:0]   fill;
  logic [63:0]  total;
  logic [255:0] hash;
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [5:0]   rnd;
  logic [5:0]   pad_pos;
  logic         final_blk;
  logic         pad_more;
  logic [2:0]   emit_idx;

  logic         buf_we;
  logic [5:0]   buf_wa;
  logic [7:0]   buf_wd;
  logic [63:0]  bits;
  logic [31:0]  w_new;
  logic [31:0]  w_cur;
  logic [31:0]  t1;
  logic [31:0]  t2;

  assign bits  = {total[60:0], 3'b000};
  assign w_cur = w[0];
  assign w_new = sha256_pkg::sig1(w[14]) + w[9] + sha256_pkg::sig0(w[1]) + w[0];
  assign t1    = h + sha256_pkg::bsig1(e) + ((e & f) ^ (~e & g))
                 + sha256_pkg::round_const(rnd) + w_cur;
  assign t2    = sha256_pkg::bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));

  assign cmd_ready = (state == sha256_pkg::ST_IDLE);
  assign out_valid = (state == sha256_pkg::ST_EMIT);
  assign out_word  = hash[32*emit_idx +: 32];
  assign out_index = emit_idx;
  assign out_last  = (emit_idx == 3'd7);

  // next state and buffer write port
  always_comb begin
    state_next = state;
    buf_we     = 1'b0;
    buf_wa     = pad_pos;
    buf_wd     = 8'h00;
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          buf_we = 1'b1;
          buf_wa = fill;
          if (cmd.op == sha256_pkg::OP_ABSORB) begin
            buf_wd = cmd.data;
            if (fill == 6'd63) begin
              state_next = sha256_pkg::ST_LOAD;
            end
          end else begin
            buf_wd = sha256_pkg::PadByte;
            // pad byte in the last slot leaves nothing to pad in this block
            if (fill == 6'd63) begin
              state_next = sha256_pkg::ST_LOAD;
            end else begin
              state_next = sha256_pkg::ST_PAD;
            end
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        buf_we = 1'b1;
        if (final_blk && pad_pos >= sha256_pkg::LenStart) begin
          buf_wd = bits[8*(6'd63 - pad_pos) +: 8];
        end
        if (pad_pos == 6'd63) begin
          state_next = sha256_pkg::ST_LOAD;
        end
      end
      sha256_pkg::ST_LOAD: begin
        if (rnd == 6'd15) begin
          state_next = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = sha256_pkg::ST_UPDATE;
        end
      end
      sha256_pkg::ST_UPDATE: begin
        if (final_blk) begin
          state_next = sha256_pkg::ST_EMIT;
        end else if (pad_more) begin
          state_next = sha256_pkg::ST_PAD;
        end else begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_ready && emit_idx == 3'd7) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // block buffer memory, one byte lane written per cycle while buf_we is set
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_wa[5:2]][8*(2'd3 - buf_wa[1:0]) +: 8] <= buf_wd;
    end
  end

  // control and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      total     <= '0;
      hash      <= sha256_pkg::InitHash;
      rnd       <= '0;
      pad_pos   <= '0;
      final_blk <= 1'b0;
      pad_more  <= 1'b0;
      emit_idx  <= '0;
    end else begin
      case (state)
        sha256_pkg::ST_IDLE: begin
          rnd <= '0;
          if (cmd_valid) begin
            if (cmd.op == sha256_pkg::OP_ABSORB) begin
              fill    <= fill + 1'b1;
              total   <= total + 64'd1;
              pad_pos <= '0;
            end else begin
              pad_pos   <= fill + 1'b1;
              final_blk <= (fill < 6'd56);
              pad_more  <= !(fill < 6'd56);
            end
          end
        end
        sha256_pkg::ST_PAD: begin
          // wraps to zero at the end of the block
          pad_pos <= pad_pos + 1'b1;
          rnd     <= '0;
        end
        sha256_pkg::ST_LOAD: begin
          rnd <= (rnd == 6'd15) ? '0 : rnd + 1'b1;
        end
        sha256_pkg::ST_ROUND: begin
          rnd <= rnd + 1'b1;
        end
        sha256_pkg::ST_UPDATE: begin
          hash <= {hash[255:224] + h, hash[223:192] + g, hash[191:160] + f,
                   hash[159:128] + e, hash[127:96] + d, hash[95:64] + c,
                   hash[63:32] + b, hash[31:0] + a};
          rnd <= '0;
          // overflowing pad: the next block carries the length and is final
          if (!final_blk && pad_more) begin
            final_blk <= 1'b1;
            pad_more  <= 1'b0;
          end
          emit_idx <= '0;
        end
        sha256_pkg::ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd7) begin
              hash      <= sha256_pkg::InitHash;
              fill      <= '0;
              total     <= '0;
              final_blk <= 1'b0;
              pad_more  <= 1'b0;
              pad_pos   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    case (state)
      sha256_pkg::ST_LOAD: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= buf_mem[rnd[3:0]];
        {h, g, f, e, d, c, b, a} <= hash;
      end
      sha256_pkg::ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= w_new;
        h <= g;
        g <= f;
        f <= e;
        e <= d + t1;
        d <= c;
        c <= b;
        b <= a;
        a <= t1 + t2;
      end
      default: ;
    endcase
  end

endmodule

/* src/sha256_stream_hasher_unit.sv */
// sha256_stream_hasher_unit: top level of the streaming sha-256 hasher
// depends on sha256_pkg, sha256_front, sha256_queue, sha256_back
//
// usage
//   s_axis carries one word per item: tdata[7:0] is the message byte and
//   tuser is the operation (0 absorb the byte, 1 finish the message).
//   m_axis returns eight digest words after each finish, tdata[31:0] the
//   digest word and tdata[34:32] its index, with tlast on the eighth.
// processing
//   the back end takes absorbed bytes only while idle; the 64th byte of a
//   block starts a compression of load, round and update steps, paced
//   by the single shared round unit over one buffer port.
//   a finish pads the rest of the block, compresses one or two blocks
//   and then presents eight words, one per cycle when taken.
// reset
//   rst clears the queue, restores the initial hash values, the fill count
//   and the byte count; the block buffer holds no reset value.
// stall
//   while m_axis_tready is low the back end holds the current word, the
//   queue fills and then s_axis_tready drops.
module sha256_stream_hasher_unit #(
  parameter int QueueDepth = sha256_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_axis_tlast    // last_word
);

  logic             f_valid, f_ready;
  sha256_pkg::cmd_t f_cmd;
  logic             q_valid, q_ready;
  sha256_pkg::cmd_t q_cmd;
  logic [31:0]      word;
  logic [2:0]       idx;

  sha256_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tuser), .in_data(s_axis_tdata),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  sha256_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_word(word), .out_index(idx), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, idx, word};

endmodule

/* src/sha256_checker.sv */
// sha256_checker: port-level assertions for the stream hasher, bound to the top level
// depends on sha256_stream_hasher_unit ports only
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // tlast marks word index seven only
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast does not match word index");

  // word index advances after an accepted non-last word
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest words out of order");

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

  // fill bits stay zero
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39:35] == 5'd0))
    else $error("nonzero fill bits");

  // input ready is always a defined level while a word is offered
  a_in_ready_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid |-> !$isunknown(s_axis_tready))
    else $error("input ready unknown");

endmodule

bind sha256_stream_hasher_unit sha256_checker u_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

/* sim/sha256_stream_hasher_unit_checker.sv */
// sha256_stream_hasher_unit_checker: watches both streams, predicts each digest and compares
// depends on sha256_pkg for the operation codes
`timescale 1ns / 1ps
module sha256_stream_hasher_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int           fill;
  logic [63:0]  msg_bytes;
  digest_word_t digest_q[$];

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // one 64-round compression of blk into chain
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] s [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    s = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + KTab[i] + w[i];
      t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
      s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += s[i];
  endtask

  // absorb a byte or pad, finish and queue the eight digest words
  task automatic hash_word(sha256_pkg::op_t op, logic [7:0] b);
    logic [63:0] bits;
    if (op == sha256_pkg::OP_ABSORB) begin
      blk[fill] = b;
      fill++;
      msg_bytes++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end else begin
      bits = msg_bytes << 3;
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin blk[fill] = 8'h00; fill++; end
        compress_block();
        fill = 0;
      end
      while (fill < 56) begin blk[fill] = 8'h00; fill++; end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], 3'(i), i == 7});
      chain = HInit;
      fill = 0;
      msg_bytes = '0;
    end
  endtask

  always @(posedge clk) begin
    digest_word_t want;
    if (rst) begin
      chain = HInit;
      fill = 0;
      msg_bytes = '0;
      digest_q.delete();
      fail_count <= 0;
      pending_words <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        hash_word(sha256_pkg::op_t'(s_axis_tuser), s_axis_tdata);
      // compare output word with oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected digest word %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== want.digest || m_axis_tdata[34:32] !== want.index
              || m_axis_tlast !== want.last || m_axis_tdata[39:35] !== 5'd0) begin
            if (fail_count < 10)
              $display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                       want.digest, want.index, want.last, m_axis_tdata[31:0],
                       m_axis_tdata[34:32], m_axis_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_words <= digest_q.size();
    end
  end
endmodule

/* sim/sha256_stream_hasher_unit_test.sv */
// sha256_stream_hasher_unit_test: stimulus and verdict for the streaming sha-256 hasher
// depends on sha256_pkg, sha256_stream_hasher_unit and the checker module
`timescale 1ns / 1ps
module sha256_stream_hasher_unit_test;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending_words;
  int          word_count;
  bit          calm;

  sha256_stream_hasher_unit i_dut (.*);

  sha256_stream_hasher_unit_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one word on the input stream, with random gaps before it unless calm is set
  task automatic send_word(sha256_pkg::op_t op, logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    // ready depends on registers only, so it is settled at the falling edge
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    word_count++;
  endtask

  // a message of given length and random or fixed content, then finish
  task automatic send_message(int len, int fill_mode);
    for (int i = 0; i < len; i++)
      send_word(sha256_pkg::OP_ABSORB,
                fill_mode == 0 ? 8'($urandom) : fill_mode == 1 ? 8'h00 : 8'hff);
    send_word(sha256_pkg::OP_FINISH, 8'($urandom));
  endtask

  // receiver back-pressure in bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    calm = 1'b0;
    word_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty message finished with a nonzero byte, short messages, then padding edge lengths
    send_word(sha256_pkg::OP_FINISH, 8'hff);
    send_message(1, 2);
    send_message(3, 1);
    send_message(0, 0);
    // wait for all digests before continuing
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    send_message(55, 0);
    send_message(56, 0);
    send_message(63, 2);
    send_message(64, 0);
    send_message(119, 0);
    // random messages
    while (word_count < 420) begin
      if ($urandom_range(0, 3) == 0) send_message($urandom_range(0, 8), 0);
      else send_message($urandom_range(0, 130), 0);
      if (word_count > 380) calm = 1'b1;
    end
    calm = 1'b1;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* sha256_stream_hasher_unit.f */
src/sha256_pkg.sv
src/sha256_queue.sv
src/sha256_front.sv
src/sha256_back.sv
src/sha256_stream_hasher_unit.sv
src/sha256_checker.sv
sim/sha256_stream_hasher_unit_checker.sv
sim/sha256_stream_hasher_unit_test.sv
